// ===== src/gwwk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwk_pkg: shared definitions for the kerned greedy word-wrap engine
// Widths, code point constants, request and command types, and the
// saturating width adder.
// ----------------------------------------------------------------------------
package gwwk_pkg;

  localparam int GLYPHS_DEF = 256;
  localparam int KERN_PAIRS_DEF = 256;

  localparam int CP_W = 21;
  localparam int VAL_W = 16;
  localparam int IDX_W = 16;
  localparam int LW_W = 24;
  localparam int ADV_W = 17;

  localparam logic [CP_W-1:0] DEFAULT_GLYPH = 21'h0025A1;
  localparam logic [CP_W-1:0] NEWLINE_CP = 21'h00000A;
  localparam logic [CP_W-1:0] SPACE_CP = 21'h000020;
  localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;
  localparam logic [VAL_W-1:0] MAX_WIDTH_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_GLYPH = 2'd0,
    REQ_KERN  = 2'd1,
    REQ_CHAR  = 2'd2,
    REQ_START = 2'd3
  } req_t;

  typedef struct packed {
    req_t                    kind;
    logic                    is_newline;
    logic                    is_space;
    logic [CP_W-1:0]         cp;
    logic [CP_W-1:0]         cp2;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  function automatic logic signed [LW_W-1:0] sat24(input logic signed [LW_W-1:0] a,
                                                   input logic signed [ADV_W-1:0] b);
    logic signed [LW_W:0] s;
    s = {a[LW_W-1], a} + {{(LW_W - ADV_W + 1){b[ADV_W-1]}}, b};
    if (s[LW_W] != s[LW_W-1]) begin
      return s[LW_W] ? {1'b1, {(LW_W-1){1'b0}}} : {1'b0, {(LW_W-1){1'b1}}};
    end
    return s[LW_W-1:0];
  endfunction

endpackage

// ===== src/gwwk_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwk_queue: two-entry register queue
// Decouples a producer from a consumer; each beat is stored until popped.
// ----------------------------------------------------------------------------
module gwwk_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] data [2];
  logic             head;
  logic [1:0]       count;
  logic             push_ok;
  logic             pop_ok;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok = pop && !empty;
  assign rdata = data[head];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      data[head ^ count[0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop_ok) begin
        head <= ~head;
      end
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

// ===== src/gwwk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwk_front: request decoder
// Classifies each incoming beat into a command for the back end.
// ----------------------------------------------------------------------------
module gwwk_front (
  input  logic                                   push,
  input  logic [1:0]                             req_type,
  input  logic [gwwk_pkg::CP_W-1:0]              code_point,
  input  logic [gwwk_pkg::CP_W-1:0]              second_code_point,
  input  logic signed [gwwk_pkg::VAL_W-1:0]      value,
  input  logic                                   q_full,
  output logic                                   full,
  output logic                                   q_push,
  output gwwk_pkg::cmd_t                         cmd
);

  always_comb begin
    cmd.kind = gwwk_pkg::req_t'(req_type);
    cmd.is_newline = (code_point == gwwk_pkg::NEWLINE_CP);
    cmd.is_space = (code_point == gwwk_pkg::SPACE_CP);
    cmd.cp = code_point;
    cmd.cp2 = second_code_point;
    cmd.value = value;
  end

  assign full = q_full;
  assign q_push = push && !q_full;

endmodule

// ===== src/gwwk_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwk_back: table scan and line-wrap engine
// Scans the glyph and kerning tables in parallel, then updates the tables
// or the line state and emits break indices.
// ----------------------------------------------------------------------------
module gwwk_back #(
  parameter int GLYPHS = gwwk_pkg::GLYPHS_DEF,
  parameter int KERN_PAIRS = gwwk_pkg::KERN_PAIRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gwwk_pkg::cmd_t                    cmd_in,
  input  logic                              cmd_empty,
  output logic                              cmd_pop,
  input  logic [gwwk_pkg::VAL_W-1:0]        max_width,
  input  logic                              res_full,
  output logic                              res_push,
  output logic [gwwk_pkg::IDX_W-1:0]        res_data
);

  localparam int GAW = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
  localparam int KAW = (KERN_PAIRS > 1) ? $clog2(KERN_PAIRS) : 1;
  localparam int GCW = $clog2(GLYPHS + 1);
  localparam int KCW = $clog2(KERN_PAIRS + 1);
  localparam int CP_W = gwwk_pkg::CP_W;
  localparam int VAL_W = gwwk_pkg::VAL_W;
  localparam int LW_W = gwwk_pkg::LW_W;
  localparam int ADV_W = gwwk_pkg::ADV_W;
  localparam int IDX_W = gwwk_pkg::IDX_W;

  logic [CP_W-1:0]         glyph_ids [GLYPHS];
  logic signed [VAL_W-1:0] glyph_advances [GLYPHS];
  logic [CP_W-1:0]         kern_firsts [KERN_PAIRS];
  logic [CP_W-1:0]         kern_seconds [KERN_PAIRS];
  logic signed [VAL_W-1:0] kern_amounts [KERN_PAIRS];

  gwwk_pkg::state_t state;
  gwwk_pkg::state_t state_next;
  gwwk_pkg::cmd_t   cur;

  logic [GCW-1:0] glyph_count;
  logic [KCW-1:0] kern_count;
  logic [GCW-1:0] g_addr;
  logic [KCW-1:0] k_addr;
  logic           g_more;
  logic           k_more;

  logic                    g_rd_valid;
  logic [GAW-1:0]          g_rd_idx;
  logic [CP_W-1:0]         g_rd_id;
  logic signed [VAL_W-1:0] g_rd_adv;
  logic                    k_rd_valid;
  logic [KAW-1:0]          k_rd_idx;
  logic [CP_W-1:0]         k_rd_first;
  logic [CP_W-1:0]         k_rd_second;
  logic signed [VAL_W-1:0] k_rd_amt;

  logic                    g_hit;
  logic [GAW-1:0]          g_hit_idx;
  logic signed [VAL_W-1:0] g_adv;
  logic                    d_hit;
  logic signed [VAL_W-1:0] d_adv;
  logic                    k_hit;
  logic [KAW-1:0]          k_hit_idx;
  logic signed [VAL_W-1:0] k_amt;

  logic [CP_W-1:0] key_first;
  logic [CP_W-1:0] key_second;

  logic signed [LW_W-1:0] line_width;
  logic signed [LW_W-1:0] width_since_break;
  logic [IDX_W-1:0]       break_point;
  logic                   break_valid;
  logic [CP_W-1:0]        previous_char;
  logic [IDX_W-1:0]       char_index;

  logic                   scan_done;
  logic                   apply_go;
  logic                   g_wr;
  logic [GAW-1:0]         g_wr_idx;
  logic                   k_wr;
  logic [KAW-1:0]         k_wr_idx;
  logic signed [ADV_W-1:0] adv_sum;
  logic signed [LW_W-1:0] line_width_next;
  logic signed [LW_W-1:0] width_since_break_next;
  logic [IDX_W-1:0]       break_point_next;
  logic                   break_valid_next;
  logic [IDX_W-1:0]       char_index_next;
  logic signed [LW_W-1:0] lw_add;
  logic                   emit;

  assign g_more = (g_addr < glyph_count);
  assign k_more = (k_addr < kern_count);
  assign key_first = (cur.kind == gwwk_pkg::REQ_KERN) ? cur.cp : previous_char;
  assign key_second = (cur.kind == gwwk_pkg::REQ_KERN) ? cur.cp2 : cur.cp;

  always_comb begin
    state_next = state;
    unique case (state)
      gwwk_pkg::ST_IDLE:  if (!cmd_empty) state_next = gwwk_pkg::ST_SCAN;
      gwwk_pkg::ST_SCAN:  if (scan_done) state_next = gwwk_pkg::ST_APPLY;
      gwwk_pkg::ST_APPLY: if (!res_full) state_next = gwwk_pkg::ST_IDLE;
      default:            state_next = gwwk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == gwwk_pkg::ST_IDLE) && !cmd_empty;
    scan_done = !g_more && !k_more && !g_rd_valid && !k_rd_valid;
    apply_go = (state == gwwk_pkg::ST_APPLY) && !res_full;
    g_wr = apply_go && (cur.kind == gwwk_pkg::REQ_GLYPH) &&
           (g_hit || (glyph_count < GCW'(GLYPHS)));
    g_wr_idx = g_hit ? g_hit_idx : glyph_count[GAW-1:0];
    k_wr = apply_go && (cur.kind == gwwk_pkg::REQ_KERN) &&
           (k_hit || (kern_count < KCW'(KERN_PAIRS)));
    k_wr_idx = k_hit ? k_hit_idx : kern_count[KAW-1:0];
    res_push = apply_go && (cur.kind == gwwk_pkg::REQ_CHAR) && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gwwk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (g_wr) begin
      glyph_ids[g_wr_idx] <= cur.cp;
      glyph_advances[g_wr_idx] <= cur.value;
    end
    g_rd_id <= glyph_ids[g_addr[GAW-1:0]];
    g_rd_adv <= glyph_advances[g_addr[GAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (k_wr) begin
      kern_firsts[k_wr_idx] <= cur.cp;
      kern_seconds[k_wr_idx] <= cur.cp2;
      kern_amounts[k_wr_idx] <= cur.value;
    end
    k_rd_first <= kern_firsts[k_addr[KAW-1:0]];
    k_rd_second <= kern_seconds[k_addr[KAW-1:0]];
    k_rd_amt <= kern_amounts[k_addr[KAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || state == gwwk_pkg::ST_IDLE) begin
      g_addr <= '0;
      k_addr <= '0;
      g_rd_valid <= 1'b0;
      k_rd_valid <= 1'b0;
      g_hit <= 1'b0;
      d_hit <= 1'b0;
      k_hit <= 1'b0;
    end else if (state == gwwk_pkg::ST_SCAN) begin
      if (g_more) begin
        g_addr <= g_addr + 1'b1;
      end
      if (k_more) begin
        k_addr <= k_addr + 1'b1;
      end
      g_rd_valid <= g_more;
      k_rd_valid <= k_more;
      g_rd_idx <= g_addr[GAW-1:0];
      k_rd_idx <= k_addr[KAW-1:0];
      if (g_rd_valid && g_rd_id == cur.cp) begin
        g_hit <= 1'b1;
        g_hit_idx <= g_rd_idx;
        g_adv <= g_rd_adv;
      end
      if (g_rd_valid && g_rd_id == gwwk_pkg::DEFAULT_GLYPH) begin
        d_hit <= 1'b1;
        d_adv <= g_rd_adv;
      end
      if (k_rd_valid && k_rd_first == key_first && k_rd_second == key_second) begin
        k_hit <= 1'b1;
        k_hit_idx <= k_rd_idx;
        k_amt <= k_rd_amt;
      end
    end else begin
      g_rd_valid <= 1'b0;
      k_rd_valid <= 1'b0;
    end
  end

  always_comb begin
    logic signed [ADV_W-1:0] gpart;
    logic signed [ADV_W-1:0] kpart;
    gpart = g_hit ? ADV_W'(g_adv) : (d_hit ? ADV_W'(d_adv) : '0);
    kpart = k_hit ? ADV_W'(k_amt) : '0;
    adv_sum = gpart + kpart;
    char_index_next = (char_index == gwwk_pkg::IDX_MAX) ? char_index : char_index + 1'b1;
    lw_add = gwwk_pkg::sat24(line_width, adv_sum);
    emit = 1'b0;
    if (cur.is_newline) begin
      line_width_next = '0;
      width_since_break_next = '0;
      break_point_next = break_point;
      break_valid_next = 1'b0;
    end else begin
      line_width_next = lw_add;
      if (cur.is_space) begin
        break_point_next = char_index_next;
        break_valid_next = 1'b1;
        width_since_break_next = '0;
      end else begin
        break_point_next = break_point;
        break_valid_next = break_valid;
        width_since_break_next = gwwk_pkg::sat24(width_since_break, adv_sum);
      end
      emit = break_valid_next &&
             ($signed({lw_add[LW_W-1], lw_add}) >
              $signed({{(LW_W + 1 - VAL_W){1'b0}}, max_width}));
      if (emit) begin
        line_width_next = width_since_break_next;
        width_since_break_next = '0;
        break_valid_next = 1'b0;
      end
    end
  end

  assign res_data = break_point_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count <= '0;
      kern_count <= '0;
      line_width <= '0;
      width_since_break <= '0;
      break_point <= '0;
      break_valid <= 1'b0;
      previous_char <= '0;
      char_index <= '0;
    end else if (apply_go) begin
      case (cur.kind)
        gwwk_pkg::REQ_GLYPH: begin
          if (g_wr && !g_hit) begin
            glyph_count <= glyph_count + 1'b1;
          end
        end
        gwwk_pkg::REQ_KERN: begin
          if (k_wr && !k_hit) begin
            kern_count <= kern_count + 1'b1;
          end
        end
        gwwk_pkg::REQ_START: begin
          line_width <= '0;
          width_since_break <= '0;
          break_point <= '0;
          break_valid <= 1'b0;
          previous_char <= '0;
          char_index <= '0;
        end
        default: begin
          line_width <= line_width_next;
          width_since_break <= width_since_break_next;
          break_point <= break_point_next;
          break_valid <= break_valid_next;
          char_index <= char_index_next;
          if (!cur.is_newline) begin
            previous_char <= cur.cp;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/greedy_word_wrap_kerned.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_kerned: kerned greedy word-wrap engine
// Each beat is one request: a glyph advance load, a kerning pair load, a
// text character, or a start of text. The front end decodes requests into a
// two-entry command queue; the back end handles one command at a time by
// scanning the glyph and kerning tables side by side, one entry of each per
// cycle through a single read port. Break indices leave through a two-entry
// result queue. The max_width register is written over its own channel and
// must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module greedy_word_wrap_kerned #(
  parameter int GLYPHS = gwwk_pkg::GLYPHS_DEF,
  parameter int KERN_PAIRS = gwwk_pkg::KERN_PAIRS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         req_type,
  input  logic [gwwk_pkg::CP_W-1:0]          code_point,
  input  logic [gwwk_pkg::CP_W-1:0]          second_code_point,
  input  logic signed [gwwk_pkg::VAL_W-1:0]  value,
  output logic                               empty,
  input  logic                               pop,
  output logic [gwwk_pkg::IDX_W-1:0]         break_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gwwk_pkg::VAL_W-1:0]         cfg_data
);

  localparam int CMD_W = $bits(gwwk_pkg::cmd_t);

  gwwk_pkg::cmd_t                 cmd_wr;
  gwwk_pkg::cmd_t                 cmd_rd;
  logic [CMD_W-1:0]               cmd_rd_bits;
  logic                           cmd_push;
  logic                           cmd_full;
  logic                           cmd_empty;
  logic                           cmd_pop;
  logic                           res_push;
  logic                           res_full;
  logic [gwwk_pkg::IDX_W-1:0]     res_data;
  logic [gwwk_pkg::VAL_W-1:0]     max_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width <= gwwk_pkg::MAX_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_width <= cfg_data;
    end
  end

  gwwk_front u_front (
    .push              (push),
    .req_type          (req_type),
    .code_point        (code_point),
    .second_code_point (second_code_point),
    .value             (value),
    .q_full            (cmd_full),
    .full              (full),
    .q_push            (cmd_push),
    .cmd               (cmd_wr)
  );

  gwwk_queue #(.WIDTH(CMD_W)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wr),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rd_bits),
    .empty (cmd_empty)
  );

  assign cmd_rd = gwwk_pkg::cmd_t'(cmd_rd_bits);

  gwwk_back #(.GLYPHS(GLYPHS), .KERN_PAIRS(KERN_PAIRS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .max_width (max_width),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  gwwk_queue #(.WIDTH(gwwk_pkg::IDX_W)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (break_index),
    .empty (empty)
  );

endmodule

// ===== src/gwwk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwk_checker: port-level checks for the word-wrap engine
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module gwwk_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [gwwk_pkg::IDX_W-1:0]   break_index
);

  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue not empty after reset.");

  a_reset_not_full : assert property (@(posedge clk) rst |=> !full)
    else $error("Input side full after reset.");

  a_result_held : assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("Waiting result beat disappeared.");

  a_result_stable : assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(break_index))
    else $error("Waiting result beat changed.");

endmodule

bind greedy_word_wrap_kerned gwwk_checker u_gwwk_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .break_index (break_index)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the kerned greedy word-wrap engine
// Loads glyph and kerning tables, streams directed and random texts through
// the request queue, predicts every break index with an own model of the
// line state and compares each popped result in order.
// ----------------------------------------------------------------------------
class wrap_scoreboard;
  typedef logic [gwwk_pkg::CP_W-1:0] cp_t;
  typedef logic signed [gwwk_pkg::VAL_W-1:0] val_t;
  typedef logic signed [gwwk_pkg::LW_W-1:0] lw_t;
  typedef logic [gwwk_pkg::IDX_W-1:0] idx_t;

  cp_t gids[$];
  val_t gadv[$];
  cp_t kf[$];
  cp_t ks[$];
  val_t kamt[$];
  lw_t line_w, since_brk;
  idx_t brk_pt, idx_cnt;
  logic brk_ok;
  cp_t prev_cp;
  logic [gwwk_pkg::VAL_W-1:0] limit;
  idx_t breaks_due[$];
  int errors;

  function new();
    limit = gwwk_pkg::MAX_WIDTH_RESET;
    errors = 0;
    clear_text();
  endfunction

  function void clear_text();
    line_w = 0; since_brk = 0; brk_pt = 0; brk_ok = 0; prev_cp = 0; idx_cnt = 0;
  endfunction

  function lw_t add_sat(lw_t a, int b);
    longint s;
    s = longint'(a) + b;
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return s[gwwk_pkg::LW_W-1:0];
  endfunction

  function void load_glyph(cp_t id, val_t v);
    int p;
    p = 0;
    while (p < gids.size() && gids[p] < id) p++;
    if (p < gids.size() && gids[p] == id) begin
      gadv[p] = v;
    end else if (gids.size() < gwwk_pkg::GLYPHS_DEF) begin
      gids.insert(p, id); gadv.insert(p, v);
    end
  endfunction

  function void load_kern(cp_t f, cp_t s, val_t v);
    int p;
    p = 0;
    while (p < kf.size() && {kf[p], ks[p]} < {f, s}) p++;
    if (p < kf.size() && kf[p] == f && ks[p] == s) begin
      kamt[p] = v;
    end else if (kf.size() < gwwk_pkg::KERN_PAIRS_DEF) begin
      kf.insert(p, f); ks.insert(p, s); kamt.insert(p, v);
    end
  endfunction

  function void note_request(gwwk_pkg::req_t kind, cp_t cp, cp_t cp2, val_t v);
    idx_t here;
    int adv;
    bit hit;
    case (kind)
      gwwk_pkg::REQ_GLYPH: load_glyph(cp, v);
      gwwk_pkg::REQ_KERN: load_kern(cp, cp2, v);
      gwwk_pkg::REQ_START: clear_text();
      default: begin
        here = idx_cnt;
        if (idx_cnt != gwwk_pkg::IDX_MAX) idx_cnt++;
        if (cp == gwwk_pkg::NEWLINE_CP) begin
          line_w = 0; since_brk = 0; brk_ok = 0;
          return;
        end
        adv = 0; hit = 0;
        foreach (gids[i]) if (gids[i] == cp) begin adv = gadv[i]; hit = 1; end
        if (!hit) foreach (gids[i]) if (gids[i] == gwwk_pkg::DEFAULT_GLYPH) adv = gadv[i];
        foreach (kf[i]) if (kf[i] == prev_cp && ks[i] == cp) adv += kamt[i];
        line_w = add_sat(line_w, adv);
        if (cp == gwwk_pkg::SPACE_CP) begin
          brk_pt = (here != gwwk_pkg::IDX_MAX) ? here + 1'b1 : gwwk_pkg::IDX_MAX;
          brk_ok = 1; since_brk = 0;
        end else begin
          since_brk = add_sat(since_brk, adv);
        end
        prev_cp = cp;
        if (int'(line_w) > int'(limit) && brk_ok) begin
          breaks_due = {breaks_due, brk_pt};
          line_w = since_brk; since_brk = 0; brk_ok = 0;
        end
      end
    endcase
  endfunction

  function void check_break(idx_t got);
    idx_t want;
    if (breaks_due.size() == 0) begin
      $display("%0t: unexpected break_index expected none actual %0d", $time, got);
      errors++;
      return;
    end
    want = breaks_due.pop_front();
    if (got !== want) begin
      $display("%0t: break_index mismatch expected %0d actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module testbench;
  typedef logic [gwwk_pkg::CP_W-1:0] cp_t;
  typedef logic signed [gwwk_pkg::VAL_W-1:0] val_t;

  logic clk = 0, rst = 1, push = 0, pop = 0, cfg_valid = 0;
  logic [1:0] req_type = 0;
  cp_t code_point = 0, second_code_point = 0;
  val_t value = 0;
  logic [gwwk_pkg::VAL_W-1:0] cfg_data = 0;
  logic full, empty, cfg_ready;
  logic [gwwk_pkg::IDX_W-1:0] break_index;
  int send_idle = 35, recv_idle = 75;
  logic hold_go = 0;
  logic holding = 0;
  wrap_scoreboard wrap_sb;

  greedy_word_wrap_kerned u_top (.*);

  initial forever #10 clk = ~clk;

  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    holding <= 1;
    repeat (20000) @(posedge clk);
    holding <= 0;
  end

  always @(posedge clk) begin
    if (!rst && !empty && pop) wrap_sb.check_break(break_index);
    if (rst) begin
      pop <= 0;
    end else if (holding) begin
      pop <= 0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(gwwk_pkg::req_t kind, cp_t cp, cp_t cp2, val_t v);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; req_type <= kind; code_point <= cp;
    second_code_point <= cp2; value <= v;
    do @(posedge clk); while (full);
    wrap_sb.note_request(kind, cp, cp2, v);
  endtask

  task automatic write_limit(logic [gwwk_pkg::VAL_W-1:0] w);
    push <= 0;
    while (wrap_sb.breaks_due.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    cfg_valid <= 1; cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    wrap_sb.limit = w;
  endtask

  function automatic cp_t pick_char();
    case ($urandom_range(9))
      0, 1, 2: return gwwk_pkg::SPACE_CP;
      3: return gwwk_pkg::NEWLINE_CP;
      4: return cp_t'($urandom_range(1114111));
      5: return gwwk_pkg::DEFAULT_GLYPH;
      default: return cp_t'(32'h41 + $urandom_range(7));
    endcase
  endfunction

  task automatic random_phase(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: send(gwwk_pkg::REQ_GLYPH, cp_t'(32'h41 + $urandom_range(7)), 0,
                val_t'($urandom_range(16'hFFFF)));
        1: send(gwwk_pkg::REQ_KERN, pick_char(), pick_char(),
                val_t'($urandom_range(16'hFFFF)));
        2: send(gwwk_pkg::REQ_START, cp_t'($urandom), cp_t'($urandom), val_t'($urandom));
        default: send(gwwk_pkg::REQ_CHAR, pick_char(), cp_t'($urandom), val_t'($urandom));
      endcase
    end
  endtask

  initial begin
    int i;
    wrap_sb = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(gwwk_pkg::REQ_CHAR, 21'h41, 0, 0);
    send(gwwk_pkg::REQ_GLYPH, gwwk_pkg::DEFAULT_GLYPH, 0, 16'sd100);
    send(gwwk_pkg::REQ_CHAR, 21'h1FFFFF, 0, 0);
    for (i = 0; i < 8; i++) begin
      send(gwwk_pkg::REQ_GLYPH, cp_t'(21'h41 + i), 0, 16'sd160 + 16'(i * 48));
    end
    send(gwwk_pkg::REQ_GLYPH, gwwk_pkg::SPACE_CP, 0, 16'sd64);
    send(gwwk_pkg::REQ_GLYPH, 21'h41, 0, 16'sd200);
    send(gwwk_pkg::REQ_GLYPH, 21'h1FFFFF, 0, 16'sh8000);
    send(gwwk_pkg::REQ_GLYPH, 21'h0, 0, 16'sd32767);
    send(gwwk_pkg::REQ_KERN, 21'h41, 21'h42, -16'sd40);
    send(gwwk_pkg::REQ_KERN, 21'h0, 21'h1FFFFF, 16'sd32767);
    send(gwwk_pkg::REQ_KERN, 21'h41, 21'h42, -16'sd20);
    send(gwwk_pkg::REQ_START, 0, 0, 0);
    send(gwwk_pkg::REQ_CHAR, 21'h41, 0, 0);
    send(gwwk_pkg::REQ_CHAR, gwwk_pkg::SPACE_CP, 0, 0);
    send(gwwk_pkg::REQ_CHAR, gwwk_pkg::NEWLINE_CP, 0, 0);
    write_limit(16'd0);
    for (i = 0; i < 6; i++) begin
      send(gwwk_pkg::REQ_CHAR, i[0] ? gwwk_pkg::SPACE_CP : 21'h42, 0, 0);
    end
    for (i = 0; i < 250; i++) send(gwwk_pkg::REQ_GLYPH, cp_t'(21'h100 + i), 0, 16'sd1);
    for (i = 0; i < 258; i++) send(gwwk_pkg::REQ_KERN, cp_t'(21'h100 + i), 21'h20, 16'sd1);
    write_limit(16'd800);
    hold_go = 1;
    random_phase(130);
    send_idle = 75; recv_idle = 35;
    write_limit(16'd65535);
    for (i = 0; i < 10; i++) send(gwwk_pkg::REQ_GLYPH, 21'h7000, 0, 16'sd32767);
    for (i = 0; i < 150; i++) begin
      send(gwwk_pkg::REQ_CHAR, (i % 3 != 0) ? 21'h7000 : gwwk_pkg::SPACE_CP, 0, 0);
    end
    write_limit(16'd1500);
    random_phase(130);
    send_idle = 0; recv_idle = 0;
    write_limit(16'd3000);
    random_phase(130);
    push <= 0;
    i = 0;
    while (wrap_sb.breaks_due.size() != 0 && i < 200000) begin
      @(posedge clk);
      i++;
    end
    repeat (1000) @(posedge clk);
    if (wrap_sb.errors == 0 && wrap_sb.breaks_due.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/gwwk_pkg.sv
src/gwwk_queue.sv
src/gwwk_front.sv
src/gwwk_back.sv
src/greedy_word_wrap_kerned.sv
src/gwwk_checker.sv
dv/testbench.sv
